/* rtl/isort_pkg.sv */
// Shared constants and types for the insertion sort engine.
// No dependencies; imported by isort_store and insertion_sort_engine.
`default_nettype none

package isort_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Store port request: one write and one read address per cycle
    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0]        raddr;
    } t_store_req;

endpackage

`default_nettype wire

/* rtl/insertion_sort_engine.sv */
// Insertion sort engine: one shared compare/shift step a cycle walks the store.
// Insertion reads the store, then compares and shifts each larger stored value up one place,
// then writes the key; into an empty store it writes at once, and an item on a full store is dropped.
// On a last item the store is read out, each result through read, load and wait states, with output stalls.
// Ready is high only in the idle state; one item is in work at a time.
// Reset (i_rst_n low, synchronous) empties the store and clears the overflow mark.
// Depends on isort_pkg and isort_store.
`default_nettype none

module insertion_sort_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic        s_axis_tlast,   // last_item
    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] sorted_value
    output logic             m_axis_tlast,   // last_of_run
    output logic             m_axis_tuser    // [0] overflow
);
    import isort_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_INS_RD   = 3'd1;
    localparam logic [2:0] ST_INS_CMP  = 3'd2;
    localparam logic [2:0] ST_INS_PUT  = 3'd3;
    localparam logic [2:0] ST_OUT_RD   = 3'd4;
    localparam logic [2:0] ST_OUT_LD   = 3'd5;
    localparam logic [2:0] ST_OUT_WAIT = 3'd6;

    logic [2:0]               r_state, n_state;
    logic [CNT_W-1:0]         r_fill, n_fill;
    logic                     r_dropped, n_dropped;
    logic [ADDR_W-1:0]        r_pos, n_pos;
    logic [ADDR_W-1:0]        r_k, n_k;
    logic                     r_last, n_last;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic signed [DATA_W-1:0] r_out_data, n_out_data;
    logic                     r_out_last, n_out_last;
    logic                     r_out_ovf, n_out_ovf;
    logic                     r_out_valid, n_out_valid;

    t_store_req               store_req;
    logic signed [DATA_W-1:0] store_rdata;
    logic                     full;
    logic                     greater;
    logic                     in_acc;

    isort_store u_store (
        .i_clk   (i_clk),
        .i_req   (store_req),
        .o_rdata (store_rdata)
    );

    assign full    = (r_fill == CNT_W'(CAPACITY));
    assign greater = (store_rdata > r_key);
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_ovf;

    // Sequencer and shared compare/shift step
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_dropped   = r_dropped;
        n_pos       = r_pos;
        n_k         = r_k;
        n_last      = r_last;
        n_key       = r_key;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        n_out_valid = r_out_valid;
        store_req   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_key  = $signed(s_axis_tdata);
                    n_last = s_axis_tlast;
                    n_pos  = r_fill[ADDR_W-1:0];
                    if (full) begin
                        n_dropped = 1'b1;
                        if (s_axis_tlast) begin
                            n_k     = '0;
                            n_state = ST_OUT_RD;
                        end
                    end else if (r_fill == '0) begin
                        n_state = ST_INS_PUT;
                    end else begin
                        n_state = ST_INS_RD;
                    end
                end
            end
            ST_INS_RD: begin
                store_req.raddr = r_pos - ADDR_W'(1);
                n_state         = ST_INS_CMP;
            end
            ST_INS_CMP: begin
                store_req.we = 1'b1;
                if (greater) begin
                    // shift the larger value up one place, read the next one down
                    store_req.waddr = r_pos;
                    store_req.wdata = store_rdata;
                    store_req.raddr = r_pos - ADDR_W'(2);
                    n_pos           = r_pos - ADDR_W'(1);
                    if (r_pos == ADDR_W'(1)) begin
                        n_state = ST_INS_PUT;
                    end
                end else begin
                    store_req.waddr = r_pos;
                    store_req.wdata = r_key;
                    n_fill          = r_fill + CNT_W'(1);
                    n_k             = '0;
                    n_state         = r_last ? ST_OUT_RD : ST_IDLE;
                end
            end
            ST_INS_PUT: begin
                store_req.we    = 1'b1;
                store_req.waddr = r_pos;
                store_req.wdata = r_key;
                n_fill          = r_fill + CNT_W'(1);
                n_k             = '0;
                n_state         = r_last ? ST_OUT_RD : ST_IDLE;
            end
            ST_OUT_RD: begin
                store_req.raddr = r_k;
                n_state         = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                n_out_data  = store_rdata;
                n_out_last  = ({1'b0, r_k} == r_fill - CNT_W'(1));
                n_out_ovf   = r_dropped;
                n_out_valid = 1'b1;
                n_state     = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (m_axis_tready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_fill    = '0;
                        n_dropped = 1'b0;
                        n_state   = ST_IDLE;
                    end else begin
                        n_k     = r_k + ADDR_W'(1);
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and index registers
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_k        <= n_k;
        r_last     <= n_last;
        r_key      <= n_key;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

endmodule

`default_nettype wire

/* rtl/isort_store.sv */
// Sorted value store: single write port, single registered read port.
// Depends on isort_pkg.
`default_nettype none

module isort_store (
    input  wire logic                              i_clk,
    input  wire isort_pkg::t_store_req             i_req,
    output logic signed [isort_pkg::DATA_W-1:0]    o_rdata
);
    import isort_pkg::*;

    logic signed [DATA_W-1:0] r_mem [CAPACITY];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

`default_nettype wire

/* tb/tb_insertion_sort_engine.sv */
// Self-checking testbench for insertion_sort_engine: random data sets in, sorted runs out.
// Depends on isort_pkg and the rtl sources of insertion_sort_engine (rtl/*.sv).
`timescale 1ns / 1ps

module tb_insertion_sort_engine;

    localparam int CAP          = isort_pkg::CAPACITY;
    localparam int STALL_LIMIT  = 5000;  // cycles with no request or result accepted
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int RANDOM_ITEMS = 64;

    // One input request and one sorted result
    typedef struct packed {
        logic signed [31:0] value;
        logic               last_item;
    } t_sort_req;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               last_of_run;
        logic               overflow;
    } t_sort_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] value
    logic        s_axis_tlast = 1'b0; // last_item
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] sorted_value
    logic        m_axis_tlast;        // last_of_run
    logic        m_axis_tuser;        // [0] overflow

    insertion_sort_engine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Stimulus and expectation stores
    t_sort_req req_queue[$];
    t_sort_res sorted_expect_q[$];
    t_sort_req offer_item;
    t_sort_res exp_res;

    // Idle controls; the percentages and hold requests change only on the falling edge
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req_cnt = 0;
    int unsigned hold_done_cnt = 0;
    int unsigned hold_left = 0;

    // Shadow copy of the sorted store
    logic signed [31:0] shadow_store [CAP];
    int unsigned        shadow_fill = 0;
    logic               shadow_dropped = 1'b0;

    int unsigned reqs_taken = 0;
    int unsigned results_checked = 0;
    int unsigned sets_closed = 0;
    int unsigned overflow_sets = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned quiet_cycles = 0;

    // Insert one value into the shadow store; on a last item, flush the sorted run
    task automatic sorter_take(input t_sort_req rq);
        int unsigned pos;
        t_sort_res   res;
        if (shadow_fill < CAP) begin
            pos = shadow_fill;
            // strictly greater entries move up, so equal keys keep arrival order
            while (pos > 0 && shadow_store[pos-1] > rq.value) begin
                shadow_store[pos] = shadow_store[pos-1];
                pos--;
            end
            shadow_store[pos] = rq.value;
            shadow_fill++;
        end else begin
            shadow_dropped = 1'b1;
        end
        if (rq.last_item) begin
            for (int k = 0; k < shadow_fill; k++) begin
                res.sorted_value = shadow_store[k];
                res.last_of_run  = (k == shadow_fill - 1);
                res.overflow     = shadow_dropped;
                sorted_expect_q.push_back(res);
            end
            sets_closed++;
            if (shadow_dropped) overflow_sets++;
            shadow_fill    = 0;
            shadow_dropped = 1'b0;
        end
    endtask

    // Driver: offers queued requests, holds each until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid  <= 1'b0;
            shadow_fill    = 0;
            shadow_dropped = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                sorter_take(offer_item);
                reqs_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offer_item = req_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= offer_item.value;
                    s_axis_tlast  <= offer_item.last_item;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result against the oldest expectation, drives ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (sorted_expect_q.size() == 0) begin
                    $display("%0t: unexpected result value=%0d last=%b ovf=%b", $time,
                             $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
                    mismatch_cnt++;
                end else begin
                    exp_res = sorted_expect_q.pop_front();
                    results_checked++;
                    if (m_axis_tdata !== exp_res.sorted_value) begin
                        $display("%0t: sorted_value expected %0d actual %0d", $time,
                                 exp_res.sorted_value, $signed(m_axis_tdata));
                        mismatch_cnt++;
                    end
                    if (m_axis_tlast !== exp_res.last_of_run) begin
                        $display("%0t: last_of_run expected %b actual %b", $time,
                                 exp_res.last_of_run, m_axis_tlast);
                        mismatch_cnt++;
                    end
                    if (m_axis_tuser !== exp_res.overflow) begin
                        $display("%0t: overflow expected %b actual %b", $time,
                                 exp_res.overflow, m_axis_tuser);
                        mismatch_cnt++;
                    end
                end
            end
            // long hold-off when one is requested, else random stalls
            if (hold_left == 0 && hold_done_cnt < hold_req_cnt) begin
                hold_left = HOLD_CYCLES;
                hold_done_cnt++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles where neither side moves anything
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                         STALL_LIMIT, sorted_expect_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Full-range values half the time, with extremes and a narrow band for duplicate keys
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
            3, 4:    return $urandom_range(16) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Mostly short sets, some near capacity, a few past it
    function automatic int pick_set_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(6, 1);
        if (r < 88) return $urandom_range(CAP, 7);
        return $urandom_range(CAP + 4, CAP + 1);
    endfunction

    task automatic queue_set(input int len);
        t_sort_req rq;
        for (int i = 0; i < len; i++) begin
            rq.value     = pick_value();
            rq.last_item = (i == len - 1);
            req_queue.push_back(rq);
        end
    endtask

    task automatic queue_one(input logic [31:0] v, input logic lst);
        t_sort_req rq;
        rq.value     = v;
        rq.last_item = lst;
        req_queue.push_back(rq);
    endtask

    // Sender pauses here until every request is taken and every result has come
    task automatic drain();
        while (req_queue.size() > 0 || s_axis_tvalid || sorted_expect_q.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                                input int n_items);
        int queued;
        queued = 0;
        @(negedge i_clk);
        send_idle_pct  = tx_pct;
        recv_stall_pct = rx_pct;
        while (queued < n_items) begin
            queue_set(pick_set_len());
            queued = queued + req_queue.size() - queued;
        end
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: single-element sets at both extremes
        queue_one(32'h8000_0000, 1'b1);
        queue_one(32'h7FFF_FFFF, 1'b1);
        // extremes, zero, minus one and a repeated key
        queue_one(32'h7FFF_FFFF, 1'b0);
        queue_one(32'h8000_0000, 1'b0);
        queue_one(32'h0000_0000, 1'b0);
        queue_one(32'hFFFF_FFFF, 1'b0);
        queue_one(32'h8000_0000, 1'b1);
        drain();
        // full store, then the last item dropped: overflow on every result
        for (int i = 0; i < CAP + 1; i++)
            queue_one((i % 2) ? 32'h5555_5555 - i : 32'hAAAA_AAAA + i, i == CAP);
        drain();

        // Random sets under each idle pattern
        random_phase(0, 0, RANDOM_ITEMS / 4);
        random_phase(88, 0, RANDOM_ITEMS / 4);
        random_phase(0, 88, RANDOM_ITEMS / 4);
        random_phase(15, 15, RANDOM_ITEMS / 4);

        // Receiver holds off while the sender keeps offering a 12-item set and an overflowing one
        @(negedge i_clk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req_cnt++;
        queue_set(12);
        queue_set(CAP + 2);
        drain();

        // let any late result show up before closing
        repeat (60) @(negedge i_clk);
        if (sorted_expect_q.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, sorted_expect_q.size());
        $display("Covered %0d requests in %0d sets (%0d with overflow), %0d results checked.",
                 reqs_taken, sets_closed, overflow_sets, results_checked);
        $display("Idle patterns: none, sender, receiver, both, plus one long receiver hold.");
        if (mismatch_cnt == 0 && sorted_expect_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/isort_pkg.sv
rtl/isort_store.sv
rtl/insertion_sort_engine.sv
tb/tb_insertion_sort_engine.sv
